[rtl/thw_pkg.sv]
// ----------------------------------------------------------------------------
// thw_pkg
// Shared constants, types and helpers for the tar header walker.
// ----------------------------------------------------------------------------
package thw_pkg;

  // Block geometry
  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned OFS_W       = $clog2(BLOCK_BYTES);
  localparam int unsigned BLK_W       = 32;
  localparam int unsigned SIZE_W      = 36;
  localparam int unsigned SKIP_W      = SIZE_W + 1 - OFS_W;
  localparam int unsigned KIND_W      = 3;

  // Header field offsets
  localparam logic [OFS_W-1:0] SIZE_AT   = OFS_W'(124);
  localparam logic [OFS_W-1:0] SIZE_END  = OFS_W'(124 + 12);
  localparam logic [OFS_W-1:0] TYPE_AT   = OFS_W'(156);
  localparam logic [OFS_W-1:0] MAGIC_AT  = OFS_W'(257);
  localparam logic [OFS_W-1:0] MAGIC_END = OFS_W'(257 + 5);
  localparam logic [OFS_W-1:0] LAST_OFS  = OFS_W'(BLOCK_BYTES - 1);

  // Entry kind codes
  localparam logic [KIND_W-1:0] KIND_INVALID = 3'd7;

  // ASCII digit range
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_6 = 8'h36;
  localparam logic [7:0] CHAR_7 = 8'h37;

  // One result item
  typedef struct packed {
    logic [BLK_W-1:0]  header_block;
    logic [BLK_W-1:0]  data_start_block;
    logic [SIZE_W-1:0] entry_size;
    logic [KIND_W-1:0] entry_kind;
    logic              end_of_archive;
  } thw_result_t;

  // Expected magic character at position idx of "ustar"
  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h75; // u
      3'd1:    c = 8'h73; // s
      3'd2:    c = 8'h74; // t
      3'd3:    c = 8'h61; // a
      3'd4:    c = 8'h72; // r
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/thw_parser.sv]
// ----------------------------------------------------------------------------
// thw_parser
// Per-byte walk state: block position, skip count, size/type/magic parse,
// and the result produced on the byte that ends a header or that starts a header past the archive end.
// ----------------------------------------------------------------------------
module thw_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [7:0]                 data_byte,
  input  logic [thw_pkg::BLK_W-1:0]  archive_blocks,
  output logic                       emit,
  output thw_pkg::thw_result_t       result
);
  import thw_pkg::*;

  logic [OFS_W-1:0]  offset_r,  offset_nxt;
  logic [BLK_W-1:0]  block_r,   block_nxt;
  logic [SKIP_W-1:0] skip_r,    skip_nxt;
  logic [SIZE_W-1:0] acc_r,     acc_nxt;
  logic              octal_done_r, octal_done_nxt;
  logic              magic_ok_r,   magic_ok_nxt;
  logic [KIND_W-1:0] kind_r,    kind_nxt;
  logic              stopped_r, stopped_nxt;

  logic              last;
  logic [2:0]        magic_pos;
  logic [SKIP_W-1:0] size_round;
  logic [BLK_W-1:0]  block_inc;

  assign last       = (offset_r == LAST_OFS);
  assign magic_pos  = 3'(offset_r - MAGIC_AT);
  assign size_round = SKIP_W'(({1'b0, acc_r} + (SIZE_W+1)'(BLOCK_BYTES - 1)) >> OFS_W);
  assign block_inc  = block_r + BLK_W'(1);

  // Next state and result for the byte in the input register
  always_comb begin
    offset_nxt     = offset_r;
    block_nxt      = block_r;
    skip_nxt       = skip_r;
    acc_nxt        = acc_r;
    octal_done_nxt = octal_done_r;
    magic_ok_nxt   = magic_ok_r;
    kind_nxt       = kind_r;
    stopped_nxt    = stopped_r;
    emit           = 1'b0;

    // default result is the end marker
    result.header_block     = block_r;
    result.data_start_block = '0;
    result.entry_size       = '0;
    result.entry_kind       = KIND_INVALID;
    result.end_of_archive   = 1'b1;

    if (step && !stopped_r) begin
      if (skip_r != '0) begin
        // passing over data blocks
        if (last) begin
          skip_nxt  = skip_r - SKIP_W'(1);
          offset_nxt = '0;
          block_nxt  = block_inc;
        end else begin
          offset_nxt = offset_r + OFS_W'(1);
        end
      end else if (offset_r == '0 && block_r >= archive_blocks) begin
        // header past the archive end
        emit        = 1'b1;
        stopped_nxt = 1'b1;
      end else begin
        // octal size field
        if (offset_r >= SIZE_AT && offset_r < SIZE_END && !octal_done_r) begin
          if (data_byte >= CHAR_0 && data_byte <= CHAR_7) begin
            acc_nxt = {acc_r[SIZE_W-4:0], data_byte[2:0]};
          end else begin
            octal_done_nxt = 1'b1;
          end
        end
        // type byte
        if (offset_r == TYPE_AT) begin
          if (data_byte >= CHAR_0 && data_byte <= CHAR_6) begin
            kind_nxt = data_byte[KIND_W-1:0];
          end else begin
            kind_nxt = KIND_INVALID;
          end
        end
        // magic compare
        if (offset_r >= MAGIC_AT && offset_r < MAGIC_END) begin
          if (data_byte != magic_char(magic_pos)) begin
            magic_ok_nxt = 1'b0;
          end
        end
        if (last) begin
          emit = 1'b1;
          if (!magic_ok_r) begin
            stopped_nxt = 1'b1;
          end else begin
            result.data_start_block = block_inc;
            result.entry_size       = acc_r;
            result.entry_kind       = kind_r;
            result.end_of_archive   = 1'b0;
            skip_nxt       = size_round;
            acc_nxt        = '0;
            octal_done_nxt = 1'b0;
            magic_ok_nxt   = 1'b1;
            kind_nxt       = KIND_INVALID;
            offset_nxt     = '0;
            block_nxt      = block_inc;
          end
        end else begin
          offset_nxt = offset_r + OFS_W'(1);
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r     <= '0;
      block_r      <= '0;
      skip_r       <= '0;
      acc_r        <= '0;
      octal_done_r <= 1'b0;
      magic_ok_r   <= 1'b1;
      kind_r       <= KIND_INVALID;
      stopped_r    <= 1'b0;
    end else begin
      offset_r     <= offset_nxt;
      block_r      <= block_nxt;
      skip_r       <= skip_nxt;
      acc_r        <= acc_nxt;
      octal_done_r <= octal_done_nxt;
      magic_ok_r   <= magic_ok_nxt;
      kind_r       <= kind_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

  // A stopped walk stays stopped until reset
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("walk restarted without reset");

  // Nothing is reported while data blocks are skipped
  a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (skip_r != '0) |-> !emit)
    else $error("result during data skip");

  // An entry result only comes from the final byte of a header
  a_entry_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !result.end_of_archive) |-> (offset_r == LAST_OFS && magic_ok_r))
    else $error("entry result off the header end");

endmodule

[rtl/thw_out_reg.sv]
// ----------------------------------------------------------------------------
// thw_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module thw_out_reg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  thw_pkg::thw_result_t         result,
  input  logic                         out_stall,
  output logic                         free,
  output logic                         out_valid,
  output logic [thw_pkg::BLK_W-1:0]    out_header_block,
  output logic [thw_pkg::BLK_W-1:0]    out_data_start_block,
  output logic [thw_pkg::SIZE_W-1:0]   out_entry_size,
  output logic [thw_pkg::KIND_W-1:0]   out_entry_kind,
  output logic                         out_end_of_archive
);
  import thw_pkg::*;

  logic        valid_r, valid_nxt;
  thw_result_t data_r;

  // Register is free when empty or being drained this cycle
  assign free = !valid_r || !out_stall;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid            = valid_r;
  assign out_header_block     = data_r.header_block;
  assign out_data_start_block = data_r.data_start_block;
  assign out_entry_size       = data_r.entry_size;
  assign out_entry_kind       = data_r.entry_kind;
  assign out_end_of_archive   = data_r.end_of_archive;

  // A held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_stall) |-> !load)
    else $error("result overwritten while stalled");

endmodule

[rtl/tar_header_walker_top.sv]
// ----------------------------------------------------------------------------
// tar_header_walker_top
// Walks a tar archive byte by byte, reporting each ustar header and the end.
//
//   channel  direction  handshake          payload
//   in_      in         in_valid/in_stall  in_data_byte
//   out_     out        out_valid/out_stall header, data start, size, kind, end
//   cfg_     in         cfg_valid/ready    cfg_archive_blocks
//
// One byte per cycle sustained unless a stalled result holds the input register;
// a result is loaded into the result register from the byte in the input register.
// The input register and the result register bound the timing; per-byte
// work is one state update between them.
// Reset is synchronous, active low; cfg_ready is always high.
// A stalled result holds the input register, which then stalls in_.
// ----------------------------------------------------------------------------
module tar_header_walker_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_data_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [thw_pkg::BLK_W-1:0]   out_header_block,
  output logic [thw_pkg::BLK_W-1:0]   out_data_start_block,
  output logic [thw_pkg::SIZE_W-1:0]  out_entry_size,
  output logic [thw_pkg::KIND_W-1:0]  out_entry_kind,
  output logic                        out_end_of_archive,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [thw_pkg::BLK_W-1:0]   cfg_archive_blocks
);
  import thw_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [7:0]        s1_byte_r;
  logic [BLK_W-1:0]  arch_blocks_r;
  logic              go;
  logic              step;
  logic              in_xfer;
  logic              free;
  logic              emit;
  thw_result_t       result;

  // Config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_blocks_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      arch_blocks_r <= cfg_archive_blocks;
    end
  end

  // Input register
  assign go       = free;
  assign step     = s1_valid_r && go;
  assign in_stall = s1_valid_r && !go;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_data_byte;
    end
  end

  // Walk state and parse
  thw_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .data_byte      (s1_byte_r),
    .archive_blocks (arch_blocks_r),
    .emit           (emit),
    .result         (result)
  );

  // Result register
  thw_out_reg u_out (
    .clk                  (clk),
    .rst_n                (rst_n),
    .load                 (step && emit),
    .result               (result),
    .out_stall            (out_stall),
    .free                 (free),
    .out_valid            (out_valid),
    .out_header_block     (out_header_block),
    .out_data_start_block (out_data_start_block),
    .out_entry_size       (out_entry_size),
    .out_entry_kind       (out_entry_kind),
    .out_end_of_archive   (out_end_of_archive)
  );

  // A blocked byte stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !go) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("blocked byte lost");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tar header walker. A queue of archive bytes
// (ustar headers with random content, data blocks, a terminal case) is
// streamed through the input channel in random bursts. Each accepted byte
// is run through a bit-accurate walk predictor. Each result transfer is
// compared against the oldest predicted entry.
// ----------------------------------------------------------------------------
module tb_top;
  import thw_pkg::*;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int RANDOM_ENTRIES  = 30;

  localparam logic [7:0]  CHAR_NUL   = 8'h00;
  localparam logic [7:0]  CHAR_SPACE = 8'h20;
  localparam logic [7:0]  CHAR_SLASH = 8'h2f;
  localparam logic [7:0]  CHAR_8     = 8'h38;
  localparam logic [7:0]  CHAR_9     = 8'h39;
  localparam logic [39:0] USTAR_TEXT = "ustar";

  typedef enum logic [2:0] {
    KIND_FILE, KIND_HARD_LINK, KIND_SYMLINK, KIND_CHAR_DEV,
    KIND_BLOCK_DEV, KIND_DIR, KIND_FIFO
  } entry_kind_e;

  // How the walk is brought to its stop at the end of the run
  typedef enum int {END_BAD_MAGIC, END_PAST_LIMIT, END_HUGE_SIZE} ending_e;

  logic              clk;
  logic              rst_n              = 1'b0;
  logic              in_valid           = 1'b0;
  logic              in_stall;
  logic [7:0]        in_data_byte       = 8'h00;
  logic              out_valid;
  logic              out_stall          = 1'b0;
  logic [BLK_W-1:0]  out_header_block;
  logic [BLK_W-1:0]  out_data_start_block;
  logic [SIZE_W-1:0] out_entry_size;
  logic [KIND_W-1:0] out_entry_kind;
  logic              out_end_of_archive;
  logic              cfg_valid          = 1'b0;
  logic              cfg_ready;
  logic [BLK_W-1:0]  cfg_archive_blocks = '0;

  tar_header_walker_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_header_block     (out_header_block),
    .out_data_start_block (out_data_start_block),
    .out_entry_size       (out_entry_size),
    .out_entry_kind       (out_entry_kind),
    .out_end_of_archive   (out_end_of_archive),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_archive_blocks   (cfg_archive_blocks)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Archive bytes waiting to be sent, and entries predicted but not yet seen
  logic [7:0]  archive_q[$];
  thw_result_t entries_due[$];
  int          gen_blocks  = 0;
  int          fault_count = 0;
  logic        byte_taken  = 1'b0;

  // Walk predictor state
  logic [BLK_W-1:0]  arch_limit   = '0;
  logic [OFS_W-1:0]  pos_in_block = '0;
  logic [BLK_W-1:0]  cur_block    = '0;
  logic [SKIP_W-1:0] skip_left    = '0;
  logic [SIZE_W-1:0] size_acc     = '0;
  logic              size_closed  = 1'b0;
  logic              magic_ok     = 1'b1;
  logic [KIND_W-1:0] kind_seen    = KIND_INVALID;
  logic              walk_halted  = 1'b0;

  function automatic void advance_offset();
    if (pos_in_block == LAST_OFS) begin
      pos_in_block = '0;
      cur_block    = cur_block + 1'b1;
    end else begin
      pos_in_block = pos_in_block + 1'b1;
    end
  endfunction

  function automatic void emit_end_entry();
    thw_result_t r;
    r.header_block     = cur_block;
    r.data_start_block = '0;
    r.entry_size       = '0;
    r.entry_kind       = KIND_INVALID;
    r.end_of_archive   = 1'b1;
    entries_due.push_back(r);
    walk_halted = 1'b1;
  endfunction

  // Advance the walk by one archive byte; queue the entry it completes
  function automatic void walk_archive_byte(input logic [7:0] b);
    thw_result_t       r;
    logic              last_byte;
    logic [SIZE_W:0]   rounded;
    last_byte = (pos_in_block == LAST_OFS);
    if (walk_halted)
      return;
    // data blocks are passed over
    if (skip_left != 0) begin
      if (last_byte)
        skip_left = skip_left - 1'b1;
      advance_offset();
      return;
    end
    // header at or past the archive length
    if (pos_in_block == 0 && cur_block >= arch_limit) begin
      emit_end_entry();
      return;
    end
    // octal size field, ends at first non-octal byte
    if (pos_in_block >= SIZE_AT && pos_in_block < SIZE_END && !size_closed) begin
      if (b >= CHAR_0 && b <= CHAR_7)
        size_acc = {size_acc[SIZE_W-4:0], b[2:0]};
      else
        size_closed = 1'b1;
    end
    if (pos_in_block == TYPE_AT) begin
      if (b >= CHAR_0 && b <= CHAR_6)
        kind_seen = KIND_W'(b - CHAR_0);
      else
        kind_seen = KIND_INVALID;
    end
    if (pos_in_block >= MAGIC_AT && pos_in_block < MAGIC_END) begin
      if (b != USTAR_TEXT[39 - 8 * (pos_in_block - MAGIC_AT) -: 8])
        magic_ok = 1'b0;
    end
    if (last_byte) begin
      if (!magic_ok) begin
        emit_end_entry();
        return;
      end
      r.header_block     = cur_block;
      r.data_start_block = cur_block + 1'b1;
      r.entry_size       = size_acc;
      r.entry_kind       = kind_seen;
      r.end_of_archive   = 1'b0;
      entries_due.push_back(r);
      rounded   = {1'b0, size_acc} + (SIZE_W + 1)'(BLOCK_BYTES - 1);
      skip_left = SKIP_W'(rounded >> OFS_W);
      size_acc    = '0;
      size_closed = 1'b0;
      magic_ok    = 1'b1;
      kind_seen   = KIND_INVALID;
    end
    advance_offset();
  endfunction

  // Any byte that cannot continue an octal number
  function automatic logic [7:0] pick_terminator();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = CHAR_NUL;
      1: c = CHAR_SPACE;
      2: c = $urandom_range(0, 1) ? CHAR_8 : CHAR_9;
      default: begin
        c = 8'($urandom_range(0, 255));
        while (c >= CHAR_0 && c <= CHAR_7)
          c = 8'($urandom_range(0, 255));
      end
    endcase
    return c;
  endfunction

  // One header block: random filler, size field of pad digits, type, magic
  function automatic void push_header(input longint unsigned size_val, input int pad,
                                      input logic [7:0] term, input logic [7:0] kind_byte,
                                      input bit bad_magic);
    logic [7:0]        hdr[BLOCK_BYTES];
    longint unsigned   rest;
    int                ndig;
    int                spot;
    ndig = 0;
    for (rest = size_val; rest != 0; rest = rest >> 3)
      ndig++;
    if (pad < ndig)
      pad = ndig;
    for (int i = 0; i < BLOCK_BYTES; i++)
      hdr[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < pad; i++)
      hdr[SIZE_AT + i] = CHAR_0 + 8'((size_val >> (3 * (pad - 1 - i))) & 7);
    if (pad < 12)
      hdr[SIZE_AT + pad] = term;
    hdr[TYPE_AT] = kind_byte;
    for (int i = 0; i < 5; i++)
      hdr[MAGIC_AT + i] = USTAR_TEXT[39 - 8 * i -: 8];
    if (bad_magic) begin
      spot = $urandom_range(0, 4);
      hdr[MAGIC_AT + spot] = hdr[MAGIC_AT + spot] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < BLOCK_BYTES; i++)
      archive_q.push_back(hdr[i]);
    gen_blocks++;
  endfunction

  function automatic void push_data_blocks(input int n);
    for (int i = 0; i < n * BLOCK_BYTES; i++)
      archive_q.push_back(8'($urandom_range(0, 255)));
    gen_blocks += n;
  endfunction

  function automatic void push_entry(input longint unsigned size_val, input int pad,
                                     input logic [7:0] term, input logic [7:0] kind_byte);
    push_header(size_val, pad, term, kind_byte, 1'b0);
    push_data_blocks(int'((size_val + BLOCK_BYTES - 1) / BLOCK_BYTES));
  endfunction

  // Well-formed entry with random size, padding, terminator and type
  function automatic void push_random_entry();
    longint unsigned sz;
    logic [7:0]      kind_byte;
    case ($urandom_range(0, 9))
      0, 1:    sz = 0;
      8:       sz = BLOCK_BYTES * $urandom_range(1, 4);
      9:       sz = $urandom_range(1, 600);
      default: sz = $urandom_range(1, 2560);
    endcase
    if ($urandom_range(0, 3) == 0)
      kind_byte = 8'($urandom_range(0, 255));
    else
      kind_byte = CHAR_0 + 8'($urandom_range(0, 7));
    push_entry(sz, $urandom_range(0, 12), pick_terminator(), kind_byte);
  endfunction

  // Wait until every byte is sent and every entry seen, then let the pipe empty
  task automatic wait_drained();
    while (archive_q.size() != 0 || in_valid || entries_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [BLK_W-1:0] v);
    @(negedge clk);
    cfg_valid          <= 1'b1;
    cfg_archive_blocks <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    arch_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !byte_taken) begin
      // hold the stalled byte
    end else if (gap_left != 0 || archive_q.size() == 0) begin
      in_valid <= 1'b0;
      if (gap_left != 0)
        gap_left--;
    end else begin
      in_valid     <= 1'b1;
      in_data_byte <= archive_q.pop_front();
      if (burst_left <= 1) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(500, 3000)
                                                 : $urandom_range(1, 40);
        gap_left   = $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end
  end

  // Receiver: alternating free and stalled runs, some long free stretches
  int   stall_run = 0;
  logic stalling  = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stalling = !stalling;
        if (stalling)
          stall_run = $urandom_range(1, 12);
        else
          stall_run = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 800)
                                                  : $urandom_range(1, 30);
      end
      stall_run--;
      out_stall <= stalling;
    end
  end

  // Monitor: check result transfers, predict from byte transfers
  always @(posedge clk) begin
    thw_result_t got;
    thw_result_t want;
    byte_taken = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      got.header_block     = out_header_block;
      got.data_start_block = out_data_start_block;
      got.entry_size       = out_entry_size;
      got.entry_kind       = out_entry_kind;
      got.end_of_archive   = out_end_of_archive;
      if (entries_due.size() == 0) begin
        if (fault_count < 10)
          $display("unexpected entry: hdr %0d start %0d size %0d kind %0d end %0d",
                   got.header_block, got.data_start_block, got.entry_size,
                   got.entry_kind, got.end_of_archive);
        fault_count++;
      end else begin
        want = entries_due.pop_front();
        if (got.header_block !== want.header_block ||
            got.data_start_block !== want.data_start_block ||
            got.entry_size !== want.entry_size ||
            got.entry_kind !== want.entry_kind ||
            got.end_of_archive !== want.end_of_archive) begin
          if (fault_count < 10)
            $display({"entry mismatch (exp/got): hdr %0d/%0d start %0d/%0d ",
                      "size %0d/%0d kind %0d/%0d end %0d/%0d"},
                     want.header_block, got.header_block,
                     want.data_start_block, got.data_start_block,
                     want.entry_size, got.entry_size,
                     want.entry_kind, got.entry_kind,
                     want.end_of_archive, got.end_of_archive);
          fault_count++;
        end
      end
    end
    if (byte_taken)
      walk_archive_byte(in_data_byte);
  end

  // Watchdog: cycles with no transfer on any channel
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus
  initial begin
    ending_e ending;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    write_limit(32'hffff_ffff);

    // directed: every type code, size field edge forms, block rounding
    push_entry(0, 11, CHAR_NUL, CHAR_0 + KIND_FILE);
    push_entry(512, 12, CHAR_NUL, CHAR_0 + KIND_DIR);
    push_entry(15, 2, CHAR_8, CHAR_0 + KIND_HARD_LINK);
    push_entry(1, 1, CHAR_9, CHAR_0 + KIND_SYMLINK);
    push_entry(513, 4, CHAR_NUL, CHAR_0 + KIND_CHAR_DEV);
    push_entry(0, 0, CHAR_SPACE, CHAR_0 + KIND_BLOCK_DEV);
    push_entry(1536, 6, CHAR_SLASH, CHAR_0 + KIND_FIFO);
    push_entry(7, 1, CHAR_NUL, CHAR_7);
    push_entry(0, 12, CHAR_NUL, 8'hff);
    push_entry(0, 3, CHAR_8, CHAR_SLASH);
    push_entry(63, 2, CHAR_NUL, CHAR_8);
    push_entry(511, 3, CHAR_SPACE, CHAR_NUL);
    wait_drained();

    write_limit(BLK_W'(gen_blocks + 400 + $urandom_range(0, 1000000)));
    repeat (RANDOM_ENTRIES) push_random_entry();
    wait_drained();

    // limit one past this header: it passes, its data blocks run past the end
    write_limit(BLK_W'(gen_blocks + 1));
    push_entry($urandom_range(513, 2560), $urandom_range(0, 12), pick_terminator(),
               CHAR_0 + 8'($urandom_range(0, 7)));
    wait_drained();

    write_limit(BLK_W'(gen_blocks + 400 + $urandom_range(0, 1000)));
    repeat (RANDOM_ENTRIES) push_random_entry();
    wait_drained();

    // stop the walk one way or another; later bytes must be ignored
    ending = ending_e'($urandom_range(0, 2));
    case (ending)
      END_BAD_MAGIC: begin
        push_header($urandom_range(0, 2000), 12, CHAR_NUL, CHAR_0, 1'b1);
        push_data_blocks(1);
        wait_drained();
        write_limit(32'hffff_ffff);
        push_random_entry();
      end
      END_PAST_LIMIT: begin
        write_limit($urandom_range(0, 1) ? '0 : BLK_W'(gen_blocks));
        push_random_entry();
        wait_drained();
        write_limit(32'hffff_ffff);
        push_random_entry();
      end
      default: begin
        // all-sevens size: largest value, skip far beyond the run
        push_header((64'd1 << SIZE_W) - 1, 12, CHAR_NUL, CHAR_0 + KIND_FILE, 1'b0);
        push_data_blocks(2);
      end
    endcase
    wait_drained();

    if (fault_count == 0 && entries_due.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
